FILE: hdl/qws_pkg.sv
`timescale 1ns / 1ps
// qws_pkg: shared widths, limits and register codes for the queue wait statistics block.
// No dependencies; imported by qws_divider and queue_wait_statistics.
package qws_pkg;

  // field and statistic widths
  localparam int ARR_W    = 5;   // arrivals field
  localparam int RATE_W   = 5;   // service_rate register
  localparam int SERVED_W = 5;   // served_now field
  localparam int STAMP_W  = 32;  // tick counter, stamps, waits
  localparam int SUM_W    = 48;  // running wait sum
  localparam int DATA_W   = 32;  // config bus data
  localparam int ADDR_W   = 3;   // config bus address

  // per-tick limits
  localparam logic [ARR_W-1:0]  MAX_ARRIVALS = ARR_W'(16);
  localparam logic [RATE_W-1:0] MAX_RATE     = RATE_W'(16);

  // register indexes (byte address = 4 * index)
  localparam int REG_IDX_W = 1;
  localparam logic [REG_IDX_W-1:0] REG_SERVICE_RATE = 1'b0;

  // service rate after reset
  localparam logic [RATE_W-1:0] RATE_RESET = RATE_W'(1);

endpackage

FILE: hdl/queue_wait_statistics.sv
`timescale 1ns / 1ps
// queue_wait_statistics: single-server queue, one tick per input word, one result word per tick.
// Per tick: ST_ENQ stores the n arrivals (dropped when the queue is full), ST_SRV_RD/ST_SRV_UPD
// serve s entries up to the rate, ST_DIV runs the 48-step mean divider when s > 0 (idle ticks reuse
// the last mean), ST_FIN loads the result word. A new word is taken only when back in ST_IDLE.
// Sync active-high reset clears queue pointers, statistics and the rate register (1); the stamp
// memory is not cleared. Depends on qws_pkg and qws_divider.
module queue_wait_statistics #(
  parameter int FIFO_DEPTH = 256
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // input channel
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [qws_pkg::ARR_W-1:0]            arrivals,
  // output channel
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [$clog2(FIFO_DEPTH+1)-1:0]      queue_length,
  output logic [qws_pkg::SERVED_W-1:0]         served_now,
  output logic [$clog2(FIFO_DEPTH+1)-1:0]      peak_length,
  output logic [qws_pkg::STAMP_W-1:0]          longest_wait,
  output logic [qws_pkg::STAMP_W-1:0]          mean_wait,
  output logic                                 dropped_flag,
  // config port
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [qws_pkg::ADDR_W-1:0]           paddr,
  input  logic [qws_pkg::DATA_W-1:0]           pwdata,
  output logic [qws_pkg::DATA_W-1:0]           prdata,
  output logic                                 pready
);
  import qws_pkg::*;

  localparam int CW = $clog2(FIFO_DEPTH + 1);
  localparam int AW = $clog2(FIFO_DEPTH);
  localparam logic [CW-1:0] FULL_COUNT = CW'(FIFO_DEPTH);
  localparam logic [AW-1:0] LAST_ADDR  = AW'(FIFO_DEPTH - 1);

  typedef enum logic [5:0] {
    ST_IDLE    = 6'b000001,
    ST_ENQ     = 6'b000010,
    ST_SRV_RD  = 6'b000100,
    ST_SRV_UPD = 6'b001000,
    ST_DIV     = 6'b010000,
    ST_FIN     = 6'b100000
  } state_t;

  state_t state;

  // config
  logic [RATE_W-1:0] service_rate;
  logic              cfg_write;

  // queue and statistics
  logic [STAMP_W-1:0] stamps [FIFO_DEPTH];
  logic [STAMP_W-1:0] rd_data;
  logic [CW-1:0]      fifo_count;
  logic [AW-1:0]      fifo_head;
  logic [AW-1:0]      fifo_tail;
  logic [STAMP_W-1:0] tick_now;
  logic [STAMP_W-1:0] served_total;
  logic [SUM_W-1:0]   wait_sum;
  logic [STAMP_W-1:0] wait_peak;
  logic [CW-1:0]      length_peak;
  logic [STAMP_W-1:0] mean_reg;

  // per-tick working registers
  logic [ARR_W-1:0]    n_left;
  logic [RATE_W-1:0]   rate_eff;
  logic [SERVED_W-1:0] served;
  logic                dropped;

  // serve step arithmetic
  logic [STAMP_W-1:0] wait_now;
  logic [SUM_W:0]     sum_ext;
  logic               can_serve;

  // divider
  logic               div_start;
  logic               div_done;
  logic [SUM_W-1:0]   div_quot;

  // ---------------------------------------------------------------- config port
  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      service_rate <= RATE_RESET;
    end else if (cfg_write && paddr[2] == REG_SERVICE_RATE) begin
      service_rate <= pwdata[RATE_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_SERVICE_RATE) begin
      prdata = DATA_W'(service_rate);
    end
  end

  // ---------------------------------------------------------------- stamp memory
  always_ff @(posedge clk) begin
    if (state == ST_ENQ && n_left != '0 && fifo_count != FULL_COUNT) begin
      stamps[fifo_tail] <= tick_now;
    end
    rd_data <= stamps[fifo_head];
  end

  // ---------------------------------------------------------------- serve arithmetic
  assign wait_now  = tick_now - rd_data;
  assign sum_ext   = {1'b0, wait_sum} + (SUM_W+1)'(wait_now);
  assign can_serve = (SERVED_W'(rate_eff) > served) && (fifo_count != '0);
  assign div_start = (state == ST_SRV_RD) && !can_serve && (served != '0);

  qws_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (wait_sum),
    .divisor  (served_total),
    .done     (div_done),
    .quotient (div_quot)
  );

  assign in_stall = (state != ST_IDLE);

  // ---------------------------------------------------------------- sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      fifo_count   <= '0;
      fifo_head    <= '0;
      fifo_tail    <= '0;
      tick_now     <= '0;
      served_total <= '0;
      wait_sum     <= '0;
      wait_peak    <= '0;
      length_peak  <= '0;
      mean_reg     <= '0;
      out_valid    <= 1'b0;
    end else begin
      // output word: set on load, cleared when taken
      if (state == ST_FIN) begin
        if (!out_valid || !out_stall) begin
          out_valid <= 1'b1;
        end
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            state <= ST_ENQ;
          end
        end

        // one arrival stored per cycle
        ST_ENQ: begin
          if (n_left == '0) begin
            if (fifo_count > length_peak) begin
              length_peak <= fifo_count;
            end
            state <= ST_SRV_RD;
          end else if (fifo_count != FULL_COUNT) begin
            fifo_tail  <= (fifo_tail == LAST_ADDR) ? '0 : fifo_tail + AW'(1);
            fifo_count <= fifo_count + CW'(1);
          end
        end

        // stamp at head is being read
        ST_SRV_RD: begin
          if (can_serve) begin
            state <= ST_SRV_UPD;
          end else begin
            tick_now <= tick_now + STAMP_W'(1);
            state    <= (served != '0) ? ST_DIV : ST_FIN;
          end
        end

        // retire one entry, fold its wait into the statistics
        ST_SRV_UPD: begin
          fifo_head  <= (fifo_head == LAST_ADDR) ? '0 : fifo_head + AW'(1);
          fifo_count <= fifo_count - CW'(1);
          if (served_total != '1) begin
            served_total <= served_total + STAMP_W'(1);
          end
          wait_sum <= sum_ext[SUM_W] ? '1 : sum_ext[SUM_W-1:0];
          if (wait_now > wait_peak) begin
            wait_peak <= wait_now;
          end
          state <= ST_SRV_RD;
        end

        ST_DIV: begin
          if (div_done) begin
            mean_reg <= (div_quot[SUM_W-1:STAMP_W] != '0) ? '1 : div_quot[STAMP_W-1:0];
            state    <= ST_FIN;
          end
        end

        // load the result word once the output register is free
        ST_FIN: begin
          if (!out_valid || !out_stall) begin
            state <= ST_IDLE;
          end
        end

        default: state <= ST_IDLE;
      endcase
    end
  end

  // ---------------------------------------------------------------- per-tick registers
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        n_left   <= (arrivals > MAX_ARRIVALS) ? MAX_ARRIVALS : arrivals;
        rate_eff <= (service_rate == '0) ? RATE_W'(1) :
                    (service_rate > MAX_RATE) ? MAX_RATE : service_rate;
        served   <= '0;
        dropped  <= 1'b0;
      end
      ST_ENQ: begin
        if (n_left != '0) begin
          if (fifo_count == FULL_COUNT) begin
            dropped <= 1'b1;
            n_left  <= '0;
          end else begin
            n_left <= n_left - ARR_W'(1);
          end
        end
      end
      ST_SRV_UPD: begin
        served <= served + SERVED_W'(1);
      end
      default: begin
      end
    endcase
  end

  // ---------------------------------------------------------------- output register
  always_ff @(posedge clk) begin
    if (state == ST_FIN && (!out_valid || !out_stall)) begin
      queue_length <= fifo_count;
      served_now   <= served;
      peak_length  <= length_peak;
      longest_wait <= wait_peak;
      mean_wait    <= mean_reg;
      dropped_flag <= dropped;
    end
  end

endmodule

FILE: hdl/qws_divider.sv
`timescale 1ns / 1ps
// qws_divider: restoring divider, one quotient bit per cycle, for the mean wait.
// Depends on qws_pkg for the sum and stamp widths.
module qws_divider (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [qws_pkg::SUM_W-1:0]   dividend,
  input  logic [qws_pkg::STAMP_W-1:0] divisor,
  output logic                        done,
  output logic [qws_pkg::SUM_W-1:0]   quotient
);
  import qws_pkg::*;

  localparam int CNT_W = $clog2(SUM_W);

  logic                busy;
  logic [CNT_W-1:0]    step;
  logic [SUM_W-1:0]    acc;     // dividend shifts out, quotient shifts in
  logic [STAMP_W-1:0]  rem;
  logic [STAMP_W:0]    shifted;
  logic [STAMP_W:0]    diff;
  logic                q_bit;

  // one trial subtract per cycle
  always_comb begin
    shifted = {rem, acc[SUM_W-1]};
    diff    = shifted - {1'b0, divisor};
    q_bit   = (shifted >= {1'b0, divisor});
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + CNT_W'(1);
        if (step == CNT_W'(SUM_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      acc <= dividend;
      rem <= '0;
    end else if (busy) begin
      acc <= {acc[SUM_W-2:0], q_bit};
      rem <= q_bit ? diff[STAMP_W-1:0] : shifted[STAMP_W-1:0];
    end
  end

  assign quotient = acc;

endmodule
